/* sv/edge_aware_box_blur_3x3_core_defines.svh */
// assertion macros for the 3x3 box blur core checker
// no dependencies; taken in by the checker file only
`ifndef EDGE_AWARE_BOX_BLUR_3X3_CORE_DEFINES_SVH
`define EDGE_AWARE_BOX_BLUR_3X3_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define EAB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define EAB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/eab_pkg.sv */
`timescale 1ns / 1ps
// shared types, constants and the rounding divider for the box blur core
// no dependencies
package eab_pkg;

    localparam int CHANNEL_BITS  = 8;
    localparam int PIXEL_BITS    = 3 * CHANNEL_BITS;
    localparam int SUM_BITS      = CHANNEL_BITS + 4;
    localparam int CNT_BITS      = 4;
    localparam int FW_BITS       = 11;
    localparam int FH_BITS       = 16;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam int DEF_MAX_WIDTH = 1024;
    localparam int RST_WIDTH     = 640;
    localparam int RST_HEIGHT    = 480;

    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT = 2'd1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT,
        S_SUM,
        S_DIV
    } t_state;

    typedef struct packed {
        logic accept;
        logic shift;
        logic sum;
        logic load;
        logic row_sel;
        logic col_sel;
        logic last;
    } t_dp_cmd;

    typedef struct packed {
        logic r_ge1;
        logic r_last;
        logic c_ge1;
        logic c_last;
        logic out_free;
    } t_dp_status;

    // (2*sum + n) / (2*n) for n in 1,2,3,4,6,9; odd factors by reciprocal
    function automatic logic [CHANNEL_BITS-1:0] div_round(
        input logic [SUM_BITS-1:0] sum,
        input logic [CNT_BITS-1:0] n
    );
        logic [SUM_BITS:0]    x;
        logic [SUM_BITS:0]    y;
        logic [SUM_BITS+16:0] p;
        logic [SUM_BITS:0]    q;
        x = {sum, 1'b0} + {{(SUM_BITS+1-CNT_BITS){1'b0}}, n};
        y = '0;
        p = '0;
        q = '0;
        case (n)
            4'd1: q = x >> 1;
            4'd2: q = x >> 2;
            4'd4: q = x >> 3;
            4'd3: begin
                y = x >> 1;
                p = y * 17'd43691;
                q = (SUM_BITS+1)'(p >> 17);
            end
            4'd6: begin
                y = x >> 2;
                p = y * 17'd43691;
                q = (SUM_BITS+1)'(p >> 17);
            end
            4'd9: begin
                y = x >> 1;
                p = y * 17'd58255;
                q = (SUM_BITS+1)'(p >> 19);
            end
            default: q = x >> 1;
        endcase
        return q[CHANNEL_BITS-1:0];
    endfunction

endpackage

/* sv/eab_ctrl.sv */
`timescale 1ns / 1ps
// sequencer for the box blur core: takes a word, then walks its results
// depends on eab_pkg
module eab_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  eab_pkg::t_dp_status i_status,
    output eab_pkg::t_dp_cmd    o_cmd,
    output logic                o_in_stall
);
    import eab_pkg::*;

    t_state r_state, n_state;
    logic   r_row_sel, n_row_sel;
    logic   r_col_sel, n_col_sel;
    logic   r_has_r1, n_has_r1;
    logic   r_has_c1, n_has_c1;
    logic   r_c_first, n_c_first;
    logic   more_col, more_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_row_sel <= 1'b0;
            r_col_sel <= 1'b0;
            r_has_r1  <= 1'b0;
            r_has_c1  <= 1'b0;
            r_c_first <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_row_sel <= n_row_sel;
            r_col_sel <= n_col_sel;
            r_has_r1  <= n_has_r1;
            r_has_c1  <= n_has_c1;
            r_c_first <= n_c_first;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_row_sel = r_row_sel;
        n_col_sel = r_col_sel;
        n_has_r1  = r_has_r1;
        n_has_c1  = r_has_c1;
        n_c_first = r_c_first;
        more_col  = !r_col_sel && r_has_c1;
        more_row  = !r_row_sel && r_has_r1;
        o_cmd     = '0;
        o_cmd.row_sel = r_row_sel;
        o_cmd.col_sel = r_col_sel;
        o_cmd.last    = !more_col && !more_row;
        o_in_stall    = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                o_cmd.shift = 1'b1;
                n_has_r1    = i_status.r_last;
                n_has_c1    = i_status.c_last;
                n_c_first   = !i_status.c_ge1;
                n_row_sel   = !i_status.r_ge1;
                n_col_sel   = !i_status.c_ge1;
                if ((i_status.r_ge1 || i_status.r_last) &&
                    (i_status.c_ge1 || i_status.c_last)) begin
                    n_state = S_SUM;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    if (more_col) begin
                        n_col_sel = 1'b1;
                        n_state   = S_SUM;
                    end else if (more_row) begin
                        n_row_sel = 1'b1;
                        n_col_sel = r_c_first;
                        n_state   = S_SUM;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

/* sv/eab_datapath.sv */
`timescale 1ns / 1ps
// line stores, 3x3 window, positions, config registers, sum and divide
// depends on eab_pkg
module eab_datapath #(
    parameter int MAX_WIDTH = eab_pkg::DEF_MAX_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  eab_pkg::t_dp_cmd                    i_cmd,
    output eab_pkg::t_dp_status                 o_status,
    input  logic                                i_cfg_we,
    input  logic [eab_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [eab_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    input  logic [eab_pkg::CHANNEL_BITS-1:0]    i_red,
    input  logic [eab_pkg::CHANNEL_BITS-1:0]    i_green,
    input  logic [eab_pkg::CHANNEL_BITS-1:0]    i_blue,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic [eab_pkg::CHANNEL_BITS-1:0]    o_out_red,
    output logic [eab_pkg::CHANNEL_BITS-1:0]    o_out_green,
    output logic [eab_pkg::CHANNEL_BITS-1:0]    o_out_blue,
    output logic                                o_frame_done,
    output logic                                o_last
);
    import eab_pkg::*;

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = $clog2(MAX_WIDTH + 1) + 1;
    // a store wider than the register can hold never clamps
    localparam logic [FW_BITS-1:0] MAXW =
        (MAX_WIDTH >= (1 << FW_BITS)) ? '1 : FW_BITS'(MAX_WIDTH);

    logic [PIXEL_BITS-1:0] mem_old [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] mem_new [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] r_rd_old, r_rd_new, r_px;
    logic [PIXEL_BITS-1:0] r_win [3][3];
    logic [FW_BITS-1:0]    r_fw;
    logic [FH_BITS-1:0]    r_fh;
    logic [AW-1:0]         r_col;
    logic [FH_BITS-1:0]    r_row;
    logic                  r_r_ge2, r_r_ge1, r_c_ge2, r_c_ge1;
    logic [SUM_BITS-1:0]   r_sum [3];
    logic [CNT_BITS-1:0]   r_n;
    logic                  r_out_valid;
    logic [CHANNEL_BITS-1:0] r_out [3];
    logic                  r_frame_done, r_last;

    logic [FW_BITS-1:0]    eff_w;
    logic [FH_BITS-1:0]    eff_h;
    logic                  col_end, row_end, cfg_hit;
    logic [2:0]            row_mask, col_mask;
    logic [SUM_BITS-1:0]   n_sum [3];
    logic [1:0]            n_rows, n_cols;

    assign eff_w = (r_fw == '0) ? FW_BITS'(1) : ((r_fw > MAXW) ? MAXW : r_fw);
    assign eff_h = (r_fh == '0) ? FH_BITS'(1) : r_fh;
    assign col_end = (WW'(r_col) == WW'(eff_w) - WW'(1));
    assign row_end = (r_row == eff_h - FH_BITS'(1));
    assign cfg_hit = i_cfg_we &&
                     (i_cfg_index == CFG_FRAME_WIDTH || i_cfg_index == CFG_FRAME_HEIGHT);

    assign o_status.r_ge1    = (r_row != '0);
    assign o_status.r_last   = row_end;
    assign o_status.c_ge1    = (r_col != '0);
    assign o_status.c_last   = col_end;
    assign o_status.out_free = !r_out_valid || !i_out_stall;

    // line stores, read on acceptance, written as the window shifts
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rd_old <= mem_old[r_col];
        end
        if (i_cmd.shift) begin
            mem_old[r_col] <= r_rd_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rd_new <= mem_new[r_col];
        end
        if (i_cmd.shift) begin
            mem_new[r_col] <= r_px;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_px <= {i_red, i_green, i_blue};
        end
        if (i_cmd.shift) begin
            r_r_ge2 <= (r_row > FH_BITS'(1));
            r_r_ge1 <= (r_row != '0);
            r_c_ge2 <= (r_col > AW'(1));
            r_c_ge1 <= (r_col != '0);
        end
    end

    // config registers, positions and window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw  <= FW_BITS'(RST_WIDTH);
            r_fh  <= FH_BITS'(RST_HEIGHT);
            r_col <= '0;
            r_row <= '0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else if (cfg_hit) begin
            if (i_cfg_index == CFG_FRAME_WIDTH) begin
                r_fw <= i_cfg_data[FW_BITS-1:0];
            end else begin
                r_fh <= i_cfg_data[FH_BITS-1:0];
            end
            r_col <= '0;
            r_row <= '0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else if (i_cmd.shift) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i][0] <= r_win[i][1];
                r_win[i][1] <= r_win[i][2];
            end
            r_win[0][2] <= r_rd_old;
            r_win[1][2] <= r_rd_new;
            r_win[2][2] <= r_px;
            if (col_end) begin
                r_col <= '0;
                r_row <= row_end ? '0 : r_row + FH_BITS'(1);
            end else begin
                r_col <= r_col + AW'(1);
            end
        end
    end

    // neighbours inside the frame: bit k is window row or column k
    assign row_mask = i_cmd.row_sel ? {1'b1, r_r_ge1, 1'b0} : {1'b1, 1'b1, r_r_ge2};
    assign col_mask = i_cmd.col_sel ? {1'b1, r_c_ge1, 1'b0} : {1'b1, 1'b1, r_c_ge2};
    assign n_rows = 2'(row_mask[0]) + 2'(row_mask[1]) + 2'(row_mask[2]);
    assign n_cols = 2'(col_mask[0]) + 2'(col_mask[1]) + 2'(col_mask[2]);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_sum[k] = '0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    if (row_mask[i] && col_mask[j]) begin
                        n_sum[k] = n_sum[k] + SUM_BITS'(
                            r_win[i][j][(2-k)*CHANNEL_BITS +: CHANNEL_BITS]);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum) begin
            r_sum <= n_sum;
            r_n   <= CNT_BITS'(n_rows) * CNT_BITS'(n_cols);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int k = 0; k < 3; k++) begin
                r_out[k] <= div_round(r_sum[k], r_n);
            end
            r_frame_done <= i_cmd.row_sel && i_cmd.col_sel;
            r_last       <= i_cmd.last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_red    = r_out[0];
    assign o_out_green  = r_out[1];
    assign o_out_blue   = r_out[2];
    assign o_frame_done = r_frame_done;
    assign o_last       = r_last;

endmodule

/* sv/edge_aware_box_blur_3x3_core.sv */
`timescale 1ns / 1ps
// 3x3 edge-normalised box blur: one input word at a time, 0 to 4 results each.
// an input word is accepted, then shifted in, then each result is summed and
// divided in turn; the divide step waits while the output is stalled.
// line stores are single-port.
// synchronous active-low reset: positions and window zero, 640 x 480 frame;
// line stores are not cleared.
module edge_aware_box_blur_3x3_core #(
    parameter int MAX_WIDTH = eab_pkg::DEF_MAX_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [eab_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [eab_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [eab_pkg::CHANNEL_BITS-1:0]  i_red,
    input  logic [eab_pkg::CHANNEL_BITS-1:0]  i_green,
    input  logic [eab_pkg::CHANNEL_BITS-1:0]  i_blue,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [eab_pkg::CHANNEL_BITS-1:0]  o_out_red,
    output logic [eab_pkg::CHANNEL_BITS-1:0]  o_out_green,
    output logic [eab_pkg::CHANNEL_BITS-1:0]  o_out_blue,
    output logic                              o_frame_done,
    output logic                              o_last
);
    import eab_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    eab_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    eab_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_out_red    (o_out_red),
        .o_out_green  (o_out_green),
        .o_out_blue   (o_out_blue),
        .o_frame_done (o_frame_done),
        .o_last       (o_last)
    );

endmodule

/* sv/eab_checker.sv */
`timescale 1ns / 1ps
// port-level checks for the box blur core, bound to the top level
// depends on edge_aware_box_blur_3x3_core_defines.svh
`include "edge_aware_box_blur_3x3_core_defines.svh"
module eab_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input logic o_frame_done,
    input logic o_last,
    input logic [7:0] o_out_red
);
    // frame end is always the final result of its word
    `EAB_ASSERT_NOW(a_done_is_last, i_clk, i_rst_n, o_out_valid && o_frame_done, o_last, "frame_done without last")
    // one word at a time: a taken word stalls the input next cycle
    `EAB_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "input taken twice in a row")
    // a stalled result holds
    `EAB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_red) && $stable(o_last), "stalled result changed")
endmodule

bind edge_aware_box_blur_3x3_core eab_checker u_eab_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_frame_done (o_frame_done),
    .o_last       (o_last),
    .o_out_red    (o_out_red)
);
